// ===== rtl/message_rate_policer_macros.svh =====
// ---------------------------------------------------------------------------
// Message rate policer assertion macros
// Shared property wrappers for the checker of the policer ports.
// ---------------------------------------------------------------------------
`ifndef MESSAGE_RATE_POLICER_MACROS_SVH
`define MESSAGE_RATE_POLICER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrp_pkg.sv =====
// ---------------------------------------------------------------------------
// Message rate policer package
// Widths, register indexes, reset values, controller states and the
// command and status bundles shared by the policer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int NUM_CLASSES = 256;
    localparam int CLASS_W     = 8;
    localparam int CLASS_RANGE = 1 << CLASS_W;
    localparam int CLS_IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int TICK_W      = 32;
    localparam int CNT_W       = 32;
    localparam int TOL_W       = 16;
    localparam int MAXMSG_W    = 16;
    localparam int RATE_W      = TOL_W + MAXMSG_W;
    localparam int SPAN_W      = TICK_W + 1;
    localparam int WIDE_W      = 2 * CNT_W;
    localparam int LHS_W       = WIDE_W + 8;
    localparam int PROD_W      = RATE_W + SPAN_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef logic [CLS_IDX_W-1:0] t_cls_idx;
    typedef logic [CLASS_W-1:0]   t_class;
    typedef logic [TICK_W-1:0]    t_tick;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [TOL_W-1:0]     t_tol;
    typedef logic [RATE_W-1:0]    t_rate;
    typedef logic [SPAN_W-1:0]    t_span;
    typedef logic [WIDE_W-1:0]    t_wide;
    typedef logic [LHS_W-1:0]     t_lhs;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes on the configuration port.
    localparam t_cfg_idx CFG_LIMITED_CLASS  = 3'd0;
    localparam t_cfg_idx CFG_MAX_MESSAGES   = 3'd1;
    localparam t_cfg_idx CFG_PER_TICKS      = 3'd2;
    localparam t_cfg_idx CFG_WARN_TOLERANCE = 3'd3;
    localparam t_cfg_idx CFG_BOOT_TOLERANCE = 3'd4;
    localparam t_cfg_idx CFG_TIME_LEEWAY    = 3'd5;
    localparam t_cfg_idx CFG_REPORT_HOLDOFF = 3'd6;

    // Register reset values; tolerances are Q8.8.
    localparam t_tol  WARN_TOL_RST = 16'd269;
    localparam t_tol  BOOT_TOL_RST = 16'd512;
    localparam t_tick LEEWAY_RST   = 32'd1200;
    localparam t_tick HOLDOFF_RST  = 32'd300;

    // Class byte to counter slot, folded modulo the table depth.
    typedef logic [CLASS_RANGE-1:0][CLS_IDX_W-1:0] t_idx_tbl;

    function automatic t_idx_tbl build_idx_tbl();
        t_idx_tbl tbl;
        for (int i = 0; i < CLASS_RANGE; i++) begin
            tbl[i] = CLS_IDX_W'(i % NUM_CLASSES);
        end
        return tbl;
    endfunction

    localparam t_idx_tbl IDX_TBL = build_idx_tbl();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_LHS,
        ST_MULW,
        ST_MULB,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic update;
        logic mul_lhs;
        logic mul_warn;
        logic mul_boot;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/mrp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Message rate policer controller
// Sequences one message through counter update, products and compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output mrp_pkg::t_dp_cmd o_cmd,
    input  mrp_pkg::t_dp_sts i_sts
);

    mrp_pkg::t_state r_state;
    mrp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mrp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = mrp_pkg::ST_UPD;
                end
            end
            mrp_pkg::ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = mrp_pkg::ST_LHS;
            end
            mrp_pkg::ST_LHS: begin
                o_cmd.mul_lhs = 1'b1;
                n_state       = mrp_pkg::ST_MULW;
            end
            mrp_pkg::ST_MULW: begin
                o_cmd.mul_warn = 1'b1;
                n_state        = mrp_pkg::ST_MULB;
            end
            mrp_pkg::ST_MULB: begin
                o_cmd.mul_boot = 1'b1;
                n_state        = mrp_pkg::ST_FIN;
            end
            mrp_pkg::ST_FIN: begin
                // Hold here until the output register can take the result.
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = mrp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mrp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mrp_dp.sv =====
// ---------------------------------------------------------------------------
// Message rate policer datapath
// Configuration registers, class counter memory, tick state, the shared
// rate multiplier, excess compares and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrp_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  mrp_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    input  mrp_pkg::t_tick        i_tick,
    input  mrp_pkg::t_class       i_msg_class,
    input  logic                  i_out_stall,
    input  mrp_pkg::t_dp_cmd      i_cmd,
    output mrp_pkg::t_dp_sts      o_sts,
    output logic                  o_out_valid,
    output logic                  o_allowed,
    output logic                  o_report,
    output mrp_pkg::t_cnt         o_class_count,
    output mrp_pkg::t_tick        o_elapsed,
    output mrp_pkg::t_cnt         o_suppressed_reports
);

    // Configuration registers.
    mrp_pkg::t_class              r_limited_class;
    logic [mrp_pkg::MAXMSG_W-1:0] r_max_msg;
    mrp_pkg::t_tick               r_per_ticks;
    mrp_pkg::t_tol                r_warn_tol;
    mrp_pkg::t_tol                r_boot_tol;
    mrp_pkg::t_tick               r_leeway;
    mrp_pkg::t_tick               r_holdoff;

    // Per-message working registers.
    mrp_pkg::t_tick    r_tick;
    mrp_pkg::t_class   r_cls;
    mrp_pkg::t_cls_idx r_idx;
    mrp_pkg::t_cnt     r_rd_data;
    logic              r_rd_vld;
    mrp_pkg::t_cnt     r_count;
    mrp_pkg::t_tick    r_elapsed;
    logic              r_limited;
    mrp_pkg::t_rate    r_wt;
    mrp_pkg::t_rate    r_bt;
    mrp_pkg::t_lhs     r_lhs;
    mrp_pkg::t_span    r_span;
    mrp_pkg::t_prod    r_prod;
    logic              r_over_w;
    logic              r_hold_ok;

    // Persistent policer state.
    mrp_pkg::t_cnt                   r_cnt_mem [mrp_pkg::NUM_CLASSES];
    logic [mrp_pkg::NUM_CLASSES-1:0] r_cnt_vld;
    mrp_pkg::t_tick                  r_start;
    mrp_pkg::t_tick                  r_last_rep;
    mrp_pkg::t_cnt                   r_suppressed;

    // Result register.
    logic           r_out_valid;
    logic           r_o_allowed;
    logic           r_o_report;
    mrp_pkg::t_cnt  r_o_count;
    mrp_pkg::t_tick r_o_elapsed;
    mrp_pkg::t_cnt  r_o_suppressed;

    mrp_pkg::t_cls_idx w_idx;
    mrp_pkg::t_cnt     w_base;
    mrp_pkg::t_cnt     n_count;
    mrp_pkg::t_tick    n_start;
    mrp_pkg::t_wide    w_cp;
    mrp_pkg::t_rate    w_mul_a;
    logic              w_over_b;
    logic              w_report;
    logic              w_suppress;
    mrp_pkg::t_cnt     n_suppressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limited_class <= '0;
            r_max_msg       <= '0;
            r_per_ticks     <= '0;
            r_warn_tol      <= mrp_pkg::WARN_TOL_RST;
            r_boot_tol      <= mrp_pkg::BOOT_TOL_RST;
            r_leeway        <= mrp_pkg::LEEWAY_RST;
            r_holdoff       <= mrp_pkg::HOLDOFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrp_pkg::CFG_LIMITED_CLASS:  r_limited_class <= i_cfg_data[mrp_pkg::CLASS_W-1:0];
                mrp_pkg::CFG_MAX_MESSAGES:   r_max_msg  <= i_cfg_data[mrp_pkg::MAXMSG_W-1:0];
                mrp_pkg::CFG_PER_TICKS:      r_per_ticks <= i_cfg_data[mrp_pkg::TICK_W-1:0];
                mrp_pkg::CFG_WARN_TOLERANCE: r_warn_tol <= i_cfg_data[mrp_pkg::TOL_W-1:0];
                mrp_pkg::CFG_BOOT_TOLERANCE: r_boot_tol <= i_cfg_data[mrp_pkg::TOL_W-1:0];
                mrp_pkg::CFG_TIME_LEEWAY:    r_leeway   <= i_cfg_data[mrp_pkg::TICK_W-1:0];
                mrp_pkg::CFG_REPORT_HOLDOFF: r_holdoff  <= i_cfg_data[mrp_pkg::TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_idx = mrp_pkg::IDX_TBL[i_msg_class];

    // Counter memory: read on accept, write back during the update step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_cnt_mem[w_idx];
        end
        if (i_cmd.update) begin
            r_cnt_mem[r_idx] <= n_count;
        end
    end

    // A slot that was never written since reset counts as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_rd_vld <= r_cnt_vld[w_idx];
            end
            if (i_cmd.update) begin
                r_cnt_vld[r_idx] <= 1'b1;
            end
        end
    end

    assign w_base  = r_rd_vld ? r_rd_data : '0;
    assign n_count = (w_base == '1) ? w_base : w_base + 1'b1;
    // A zero tick keeps the start open for the next nonzero one.
    assign n_start = (r_start == '0) ? r_tick : r_start;
    assign w_cp    = mrp_pkg::t_wide'(r_count) * mrp_pkg::t_wide'(r_per_ticks);
    assign w_mul_a = i_cmd.mul_boot ? r_bt : r_wt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tick <= i_tick;
            r_cls  <= i_msg_class;
            r_idx  <= w_idx;
        end
        if (i_cmd.update) begin
            r_count   <= n_count;
            r_elapsed <= r_tick - n_start;
            r_limited <= (r_cls == r_limited_class) && (r_per_ticks != '0);
            r_wt      <= mrp_pkg::t_rate'(r_warn_tol) * mrp_pkg::t_rate'(r_max_msg);
            r_bt      <= mrp_pkg::t_rate'(r_boot_tol) * mrp_pkg::t_rate'(r_max_msg);
        end
        if (i_cmd.mul_lhs) begin
            r_lhs  <= {w_cp, 8'h00};
            r_span <= mrp_pkg::t_span'(r_elapsed) + mrp_pkg::t_span'(r_leeway);
        end
        if (i_cmd.mul_warn || i_cmd.mul_boot) begin
            r_prod <= mrp_pkg::t_prod'(w_mul_a) * mrp_pkg::t_prod'(r_span);
        end
        // r_prod still holds the warn-level product during the boot step.
        if (i_cmd.mul_boot) begin
            r_over_w  <= r_lhs > mrp_pkg::t_lhs'(r_prod);
            r_hold_ok <= mrp_pkg::t_span'(r_tick) >
                         (mrp_pkg::t_span'(r_holdoff) + mrp_pkg::t_span'(r_last_rep));
        end
    end

    assign w_over_b     = r_lhs > mrp_pkg::t_lhs'(r_prod);
    assign w_report     = r_limited && r_over_w && r_hold_ok;
    assign w_suppress   = r_limited && r_over_w && !r_hold_ok && (r_suppressed != '1);
    assign n_suppressed = w_suppress ? r_suppressed + 1'b1 : r_suppressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= '0;
            r_last_rep   <= '0;
            r_suppressed <= '0;
        end else begin
            if (i_cmd.update) begin
                r_start <= n_start;
            end
            if (i_cmd.finish) begin
                r_suppressed <= n_suppressed;
                if (w_report) begin
                    r_last_rep <= r_tick;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_allowed    <= !(r_limited && w_over_b);
            r_o_report     <= w_report;
            r_o_count      <= r_count;
            r_o_elapsed    <= r_elapsed;
            r_o_suppressed <= n_suppressed;
        end
    end

    assign o_sts.out_free       = !r_out_valid || !i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_allowed            = r_o_allowed;
    assign o_report             = r_o_report;
    assign o_class_count        = r_o_count;
    assign o_elapsed            = r_o_elapsed;
    assign o_suppressed_reports = r_o_suppressed;

endmodule

// ===== rtl/message_rate_policer.sv =====
// ---------------------------------------------------------------------------
// Message rate policer
// The result beat is registered once the controller has walked the message through
// update, product, two shared-multiplier steps and compare; a new message is taken
// only after the result of the last one has gone into the output register.
// Reset clears all state at once, the 256 class counters through valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module message_rate_policer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_tick,
    input  logic [7:0]  i_msg_class,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_allowed,
    output logic        o_report,
    output logic [31:0] o_class_count,
    output logic [31:0] o_elapsed,
    output logic [31:0] o_suppressed_reports
);

    mrp_pkg::t_dp_cmd w_cmd;
    mrp_pkg::t_dp_sts w_sts;

    mrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    mrp_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_tick               (i_tick),
        .i_msg_class          (i_msg_class),
        .i_out_stall          (i_out_stall),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .o_out_valid          (o_out_valid),
        .o_allowed            (o_allowed),
        .o_report             (o_report),
        .o_class_count        (o_class_count),
        .o_elapsed            (o_elapsed),
        .o_suppressed_reports (o_suppressed_reports)
    );

endmodule

// ===== rtl/mrp_checker.sv =====
// ---------------------------------------------------------------------------
// Message rate policer checker
// Port-level properties of the policer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "message_rate_policer_macros.svh"

module mrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_allowed,
    input logic        o_report,
    input logic [31:0] o_class_count,
    input logic [31:0] o_elapsed,
    input logic [31:0] o_suppressed_reports
);

    logic [97:0] w_out_beat;
    logic        w_in_take;
    logic        w_out_held;

    assign w_out_beat = {o_allowed, o_report, o_class_count, o_elapsed, o_suppressed_reports};
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_held = o_out_valid && i_out_stall;

    // A stalled result beat holds still.
    `MRP_ASSERT_NEXT(a_out_hold, w_out_held, o_out_valid && $stable(w_out_beat), "held beat changed")

    // The counter of the message's own class includes that message.
    `MRP_ASSERT_NOW(a_count_nonzero, o_out_valid, o_class_count != 32'd0, "zero class count")

    // Only one message is in flight, so a taken beat closes the input.
    `MRP_ASSERT_NEXT(a_one_in_flight, w_in_take, o_in_stall, "input open after a beat")

    // A new result appears only at the end of a message's processing.
    `MRP_ASSERT_NOW(a_out_from_work, $rose(o_out_valid), $past(o_in_stall), "stray result")

endmodule

bind message_rate_policer mrp_checker u_mrp_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Message rate policer testbench
// Sends tick-stamped messages through the policer under several register
// settings and random idling on both channels. A cycle-free model of the
// policer predicts every result beat, and the monitor checks each beat field
// by field, in order. One phase holds the result channel off for a long
// stretch so that the policer backs up into its input.
// ---------------------------------------------------------------------------

module tb;

    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                HOLD_CYCLES    = 400;
    localparam int                RAND_PHASES    = 8;
    localparam int                RAND_ITEMS     = 110;
    localparam int                TAIL_CYCLES    = 20;
    localparam mrp_pkg::t_cfg_idx CFG_SPARE      = 3'd7;

    typedef struct {
        mrp_pkg::t_tick  tick;
        mrp_pkg::t_class cls;
    } t_msg;

    typedef struct {
        logic           allowed;
        logic           report;
        mrp_pkg::t_cnt  count;
        mrp_pkg::t_tick elapsed;
        mrp_pkg::t_cnt  suppressed;
    } t_verdict;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_idx   = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [31:0] i_tick      = '0;
    logic [7:0]  i_msg_class = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_allowed;
    logic        o_report;
    logic [31:0] o_class_count;
    logic [31:0] o_elapsed;
    logic [31:0] o_suppressed_reports;

    message_rate_policer uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_tick              (i_tick),
        .i_msg_class         (i_msg_class),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_allowed           (o_allowed),
        .o_report            (o_report),
        .o_class_count       (o_class_count),
        .o_elapsed           (o_elapsed),
        .o_suppressed_reports(o_suppressed_reports)
    );

    // Policer model state and its copy of the registers.
    mrp_pkg::t_cnt   class_tally [mrp_pkg::NUM_CLASSES];
    mrp_pkg::t_tick  mdl_start       = '0;
    mrp_pkg::t_tick  mdl_last        = '0;
    mrp_pkg::t_tick  mdl_last_report = '0;
    mrp_pkg::t_cnt   mdl_suppressed  = '0;
    mrp_pkg::t_class r_limited_class = '0;
    logic [15:0]     r_max_messages  = '0;
    mrp_pkg::t_tick  r_per_ticks     = '0;
    mrp_pkg::t_tol   r_warn_tol      = mrp_pkg::WARN_TOL_RST;
    mrp_pkg::t_tol   r_boot_tol      = mrp_pkg::BOOT_TOL_RST;
    mrp_pkg::t_tick  r_leeway        = mrp_pkg::LEEWAY_RST;
    mrp_pkg::t_tick  r_holdoff       = mrp_pkg::HOLDOFF_RST;

    t_msg         pending_msgs [$];
    t_verdict     verdict_q [$];

    bit           in_fired    = 1'b0;
    bit           idle_on     = 1'b1;
    bit           timed_out   = 1'b0;
    int           hold_req    = 0;
    int           hold_ack    = 0;
    int           quiet_cycles = 0;
    int           n_errors    = 0;
    int           n_msgs      = 0;
    int           n_results   = 0;
    int           n_reports   = 0;
    int           n_rejects   = 0;
    int           n_settings  = 0;

    initial begin
        for (int i = 0; i < mrp_pkg::NUM_CLASSES; i++) begin
            class_tally[i] = '0;
        end
    end

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // True when count * per_ticks * 256 exceeds tol * max_messages * span.
    function automatic logic exceeds(mrp_pkg::t_cnt c, mrp_pkg::t_tol tol,
                                     mrp_pkg::t_span span);
        logic [71:0] lhs;
        logic [71:0] rhs;
        lhs = 72'(c) * 72'(r_per_ticks) * 72'd256;
        rhs = 72'(tol) * 72'(r_max_messages) * 72'(span);
        return lhs > rhs;
    endfunction

    function automatic t_verdict police_msg(mrp_pkg::t_tick tk, mrp_pkg::t_class cl);
        t_verdict       v;
        int             slot;
        mrp_pkg::t_span span;
        slot = int'(cl) % mrp_pkg::NUM_CLASSES;
        if (mdl_start == '0) begin
            mdl_start = tk;
        end
        mdl_last = tk;
        if (class_tally[slot] != '1) begin
            class_tally[slot] = class_tally[slot] + 1'b1;
        end
        v.allowed = 1'b1;
        v.report  = 1'b0;
        v.count   = class_tally[slot];
        v.elapsed = mdl_last - mdl_start;
        if (cl == r_limited_class && r_per_ticks != '0) begin
            span = mrp_pkg::t_span'(v.elapsed) + mrp_pkg::t_span'(r_leeway);
            if (exceeds(v.count, r_warn_tol, span)) begin
                // The holdoff sum is taken one bit wider so it cannot wrap.
                if (mrp_pkg::t_span'(tk) > mrp_pkg::t_span'(r_holdoff)
                                           + mrp_pkg::t_span'(mdl_last_report)) begin
                    v.report = 1'b1;
                    mdl_last_report = tk;
                end else if (mdl_suppressed != '1) begin
                    mdl_suppressed = mdl_suppressed + 1'b1;
                end
            end
            if (exceeds(v.count, r_boot_tol, span)) begin
                v.allowed = 1'b0;
            end
        end
        v.suppressed = mdl_suppressed;
        return v;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    function automatic int gen_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    // Mostly a value from the usual range, now and then zero or the top.
    function automatic logic [31:0] pick_val(logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] top);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return top;
        end else begin
            return $urandom_range(hi, lo);
        end
    endfunction

    // The policer is idle whenever this is called, so the model copy of the
    // register is updated right away.
    task automatic write_reg(mrp_pkg::t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            mrp_pkg::CFG_LIMITED_CLASS:  r_limited_class = val[7:0];
            mrp_pkg::CFG_MAX_MESSAGES:   r_max_messages  = val[15:0];
            mrp_pkg::CFG_PER_TICKS:      r_per_ticks     = val;
            mrp_pkg::CFG_WARN_TOLERANCE: r_warn_tol      = val[15:0];
            mrp_pkg::CFG_BOOT_TOLERANCE: r_boot_tol      = val[15:0];
            mrp_pkg::CFG_TIME_LEEWAY:    r_leeway        = val;
            mrp_pkg::CFG_REPORT_HOLDOFF: r_holdoff       = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_msg(mrp_pkg::t_tick tk, mrp_pkg::t_class cl);
        t_msg m;
        m.tick = tk;
        m.cls  = cl;
        pending_msgs.push_back(m);
    endtask

    task automatic wait_drained();
        while (pending_msgs.size() != 0 || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        n_settings++;
    endtask

    // Input driver: a beat holds until it is taken, then an optional gap.
    always @(negedge i_clk) begin : in_drv
        int in_gap;
        if (!i_rst_n) begin
            in_gap = 0;
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !in_fired)) begin
            in_fired = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_msgs.size() != 0) begin
                i_in_valid  <= 1'b1;
                i_tick      <= pending_msgs[0].tick;
                i_msg_class <= pending_msgs[0].cls;
                in_gap = (idle_on && $urandom_range(0, 2) == 0) ? gen_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side stall, with the long hold-off counted here.
    always @(negedge i_clk) begin : out_drv
        int stall_left;
        if (hold_ack != hold_req) begin
            hold_ack   = hold_req;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = gen_gap() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: prediction on accepted input beats, checking on result beats.
    always @(posedge i_clk) begin : mon
        t_verdict want;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                verdict_q.push_back(police_msg(i_tick, i_msg_class));
                pending_msgs.delete(0);
                in_fired = 1'b1;
                moved = 1'b1;
                n_msgs++;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                n_results++;
                if (verdict_q.size() == 0) begin
                    $display("%0t: result beat with no message outstanding", $time);
                    n_errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (want.report) n_reports++;
                    if (!want.allowed) n_rejects++;
                    check_field("allowed", 32'(want.allowed), 32'(o_allowed));
                    check_field("report", 32'(want.report), 32'(o_report));
                    check_field("class_count", want.count, o_class_count);
                    check_field("elapsed", want.elapsed, o_elapsed);
                    check_field("suppressed_reports", want.suppressed,
                                o_suppressed_reports);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
            end
        end
    end

    initial begin
        mrp_pkg::t_class lim;
        mrp_pkg::t_cnt   gen_cnt;
        mrp_pkg::t_tick  gen_tick;
        mrp_pkg::t_tick  tk;
        mrp_pkg::t_class cl;
        logic [63:0]     span_goal;
        int              r;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                // Reset settings: no limit. Zero ticks before the start, then
                // the start itself, the top tick, and a tick going backwards.
                write_reg(CFG_SPARE, 32'h5A5A_5A5A);
                push_msg(32'd0, 8'h00);
                push_msg(32'd0, 8'hFF);
                push_msg(32'd5, 8'h00);
                push_msg(32'hFFFF_FFFF, 8'hFF);
                push_msg(32'd3, 8'h07);
                wait_drained();

                // Limit on one class with the reset tolerances, leeway and
                // holdoff; early excesses fall inside the holdoff window.
                write_reg(mrp_pkg::CFG_LIMITED_CLASS, 32'd200);
                write_reg(mrp_pkg::CFG_MAX_MESSAGES, 32'd4);
                write_reg(mrp_pkg::CFG_PER_TICKS, 32'd5000);
                push_msg(32'd6, 8'd200);
                push_msg(32'd50, 8'd200);
                push_msg(32'd100, 8'd200);
                push_msg(32'd200, 8'd200);
                push_msg(32'd420, 8'd200);
                push_msg(32'd430, 8'd200);
                push_msg(32'd500, 8'd17);
                push_msg(32'd3000, 8'd200);
                wait_drained();

                // Every register at its top value, but the report holdoff at zero.
                write_reg(mrp_pkg::CFG_LIMITED_CLASS, 32'hFF);
                write_reg(mrp_pkg::CFG_MAX_MESSAGES, 32'hFFFF);
                write_reg(mrp_pkg::CFG_PER_TICKS, 32'hFFFF_FFFF);
                write_reg(mrp_pkg::CFG_WARN_TOLERANCE, 32'hFFFF);
                write_reg(mrp_pkg::CFG_BOOT_TOLERANCE, 32'hFFFF);
                write_reg(mrp_pkg::CFG_TIME_LEEWAY, 32'hFFFF_FFFF);
                write_reg(mrp_pkg::CFG_REPORT_HOLDOFF, 32'h0);
                push_msg(32'hFFFF_FFFF, 8'hFF);
                push_msg(32'd0, 8'hFF);
                push_msg(32'd1, 8'hFF);
                wait_drained();

                // Zero allowance: every limited message is an excess, and a
                // holdoff at the top suppresses every report.
                write_reg(mrp_pkg::CFG_LIMITED_CLASS, 32'h0);
                write_reg(mrp_pkg::CFG_MAX_MESSAGES, 32'h0);
                write_reg(mrp_pkg::CFG_WARN_TOLERANCE, 32'h0);
                write_reg(mrp_pkg::CFG_BOOT_TOLERANCE, 32'h1);
                write_reg(mrp_pkg::CFG_TIME_LEEWAY, 32'h0);
                write_reg(mrp_pkg::CFG_REPORT_HOLDOFF, 32'hFFFF_FFFF);
                push_msg(32'd100, 8'h00);
                push_msg(32'hFFFF_FFFF, 8'h00);
                push_msg(32'd7, 8'h00);
                wait_drained();

                for (int ph = 0; ph < RAND_PHASES; ph++) begin
                    r = $urandom_range(0, 3);
                    lim = (r == 0)
                          ? mrp_pkg::t_class'($urandom_range(0, 1) ? 8'hFF : 8'h00)
                          : mrp_pkg::t_class'($urandom_range(0, 255));
                    write_reg(mrp_pkg::CFG_LIMITED_CLASS, 32'(lim));
                    write_reg(mrp_pkg::CFG_MAX_MESSAGES, pick_val(1, 20, 32'hFFFF));
                    write_reg(mrp_pkg::CFG_PER_TICKS, pick_val(1, 2000, 32'hFFFF_FFFF));
                    write_reg(mrp_pkg::CFG_WARN_TOLERANCE, pick_val(200, 600, 32'hFFFF));
                    write_reg(mrp_pkg::CFG_BOOT_TOLERANCE, pick_val(300, 900, 32'hFFFF));
                    write_reg(mrp_pkg::CFG_TIME_LEEWAY, pick_val(0, 2000, 32'hFFFF_FFFF));
                    write_reg(mrp_pkg::CFG_REPORT_HOLDOFF,
                              pick_val(0, 1000, 32'hFFFF_FFFF));
                    idle_on = (ph != 5);
                    if (ph == 3) begin
                        hold_req++;
                    end

                    gen_cnt  = class_tally[int'(lim) % mrp_pkg::NUM_CLASSES];
                    gen_tick = mdl_last;
                    for (int n = 0; n < RAND_ITEMS; n++) begin
                        r = $urandom_range(0, 99);
                        if (r < 15) begin
                            tk = $urandom();
                            cl = mrp_pkg::t_class'($urandom_range(0, 255));
                        end else begin
                            cl = (r < 80) ? lim
                                          : mrp_pkg::t_class'($urandom_range(0, 255));
                            if (cl == lim && gen_cnt != '1) begin
                                gen_cnt++;
                            end
                            if (cl == lim && r_max_messages != '0) begin
                                // Aim the tick near the point where this count
                                // crosses the allowance, from well under the
                                // boot level to comfortably inside it.
                                span_goal = 64'(gen_cnt) * 64'(r_per_ticks)
                                            / 64'(r_max_messages);
                                span_goal = span_goal * $urandom_range(4, 24) / 16;
                                span_goal = (span_goal > 64'(r_leeway))
                                            ? span_goal - 64'(r_leeway)
                                            : 64'($urandom_range(0, 3));
                                tk = mdl_start + span_goal[31:0];
                            end else begin
                                tk = gen_tick + $urandom_range(0, 50);
                            end
                            gen_tick = tk;
                        end
                        push_msg(tk, cl);
                    end
                    wait_drained();
                    idle_on = 1'b1;
                end

                repeat (TAIL_CYCLES) @(negedge i_clk);
            end
            begin
                wait (timed_out);
            end
        join_any

        if (timed_out) begin
            $display("%0t: no beat moved for %0d cycles, run stopped", $time,
                     WATCHDOG_LIMIT);
        end
        if (verdict_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
            n_errors++;
        end
        $display("Sent %0d messages under %0d register settings; checked %0d results.",
                 n_msgs, n_settings, n_results);
        $display("Reports raised: %0d, rejections: %0d, suppressed count %0d, errors %0d.",
                 n_reports, n_rejects, mdl_suppressed, n_errors);
        if (!timed_out && n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mrp_pkg.sv
rtl/mrp_ctrl.sv
rtl/mrp_dp.sv
rtl/message_rate_policer.sv
rtl/mrp_checker.sv
sim/tb.sv
